>>> rtl/y64e_pkg.sv
// Package for the y64 byte stream encoder: job type, pad code and the
// six-bit to character mapping. Used by every module of the block.
package y64e_pkg;

  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned NUM_SLOTS = 4;
  localparam int unsigned SLOT_W    = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h2d;

  // One accepted byte becomes one job: up to four characters, the index of
  // the last valid slot, and whether the last slot ends the message.
  typedef struct packed {
    logic [NUM_SLOTS-1:0][CHAR_W-1:0] chars;
    logic [SLOT_W-1:0]                last_slot;
    logic                             has_end;
  } job_t;

  // Map a six-bit value onto the y64 alphabet A-Z a-z 0-9 . _
  function automatic logic [CHAR_W-1:0] y64_digit(input logic [5:0] six);
    logic [CHAR_W-1:0] v;
    v = {1'b0, six};
    if (six inside {[6'd0:6'd25]}) begin
      return v + 7'd65;
    end else if (six inside {[6'd26:6'd51]}) begin
      return v + 7'd71;
    end else if (six inside {[6'd52:6'd61]}) begin
      return v - 7'd4;
    end else if (six == 6'd62) begin
      return 7'h2e;
    end else begin
      return 7'h5f;
    end
  endfunction

endpackage

>>> rtl/y64e_front.sv
// Front part of the y64 encoder: accepts bytes, tracks the group phase and
// carried bits, and turns each byte into one job. Depends on y64e_pkg.
module y64e_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] data_byte
  input  logic                 s_tlast,   // is_final
  output logic                 push_valid,
  input  logic                 push_ready,
  output y64e_pkg::job_t       push_job
);

  logic [1:0] group_phase;
  logic [1:0] group_phase_next;
  logic [3:0] carry_bits;
  logic [3:0] carry_bits_next;
  logic       accept;

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;
  assign accept     = s_tvalid && push_ready;

  always_comb begin
    push_job           = '0;
    group_phase_next   = group_phase;
    carry_bits_next    = carry_bits;
    push_job.has_end   = s_tlast;
    case (group_phase)
      2'd1: begin
        push_job.chars[0] = y64e_pkg::y64_digit({carry_bits[1:0], s_tdata[7:4]});
        carry_bits_next   = s_tdata[3:0];
        group_phase_next  = 2'd2;
        if (s_tlast) begin
          push_job.chars[1]  = y64e_pkg::y64_digit({s_tdata[3:0], 2'b00});
          push_job.chars[2]  = y64e_pkg::PAD_CHAR;
          push_job.last_slot = 2'd2;
        end
      end
      2'd2: begin
        push_job.chars[0]  = y64e_pkg::y64_digit({carry_bits, s_tdata[7:6]});
        push_job.chars[1]  = y64e_pkg::y64_digit(s_tdata[5:0]);
        push_job.last_slot = 2'd1;
        carry_bits_next    = 4'd0;
        group_phase_next   = 2'd0;
      end
      default: begin
        // Phase zero; the unused phase code behaves the same way.
        push_job.chars[0] = y64e_pkg::y64_digit(s_tdata[7:2]);
        carry_bits_next   = {2'b00, s_tdata[1:0]};
        group_phase_next  = 2'd1;
        if (s_tlast) begin
          push_job.chars[1]  = y64e_pkg::y64_digit({s_tdata[1:0], 4'b0000});
          push_job.chars[2]  = y64e_pkg::PAD_CHAR;
          push_job.chars[3]  = y64e_pkg::PAD_CHAR;
          push_job.last_slot = 2'd3;
        end
      end
    endcase
    if (s_tlast) begin
      group_phase_next = 2'd0;
      carry_bits_next  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase <= 2'd0;
      carry_bits  <= 4'd0;
    end else if (accept) begin
      group_phase <= group_phase_next;
      carry_bits  <= carry_bits_next;
    end
  end

endmodule

>>> rtl/y64e_queue.sv
// Short job queue between the front and back parts of the y64 encoder.
// Register based, one write and one read port. Depends on y64e_pkg.
module y64e_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  y64e_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output y64e_pkg::job_t pop_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  y64e_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/y64e_back.sv
// Back part of the y64 encoder: sends the characters of queued jobs
// one per cycle while not stalled, via an output register. Uses y64e_pkg.
module y64e_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  y64e_pkg::job_t pop_job,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,   // [6:0] char_code, [7] zero
  output logic           m_tlast    // end_of_text
);

  y64e_pkg::job_t                     job;
  logic                               busy;
  logic [y64e_pkg::SLOT_W-1:0]        slot;
  logic [y64e_pkg::CHAR_W-1:0]        out_char;
  logic                               load;
  logic                               done;

  assign load      = busy && (!m_tvalid || m_tready);
  assign done      = load && (slot == job.last_slot);
  assign pop_ready = !busy || done;
  assign m_tdata   = {1'b0, out_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop_valid && pop_ready) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job  <= pop_job;
      slot <= '0;
    end else if (load) begin
      slot <= slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= job.chars[slot];
      m_tlast  <= done && job.has_end;
    end
  end

endmodule

>>> rtl/y64_byte_stream_encoder.sv
// Top level of the y64 byte stream encoder. Instantiates the front part,
// the job queue and the back part. Depends on y64e_pkg and those modules.
//
// Usage: raw bytes enter on the slave stream (s_*), one byte per request,
// with s_tlast set on the final byte of a message. Encoded characters of
// the y64 alphabet (A-Z a-z 0-9 . _) and the '-' pad leave on the master
// stream (m_*), one character per request, with m_tlast set on the final
// character of the message. A new message starts after every s_tlast.
// Each byte turns into one job at the moment it is accepted: one, two,
// three or four characters. Jobs wait in a short queue (QUEUE_DEPTH
// entries) so that the input side keeps accepting while the output side
// drains. The back part sends one character per cycle unless stalled, so
// output is the limit: a byte gives one to four characters, on average
// four characters per three bytes. With the queue empty, the job of a
// byte passes the queue, the job register and then the output register.
// If the receiver stalls, the output register holds its character, the
// back part stops taking jobs, and once the queue is full s_tready falls.
// Synchronous reset empties the queue, drops any pending character and
// returns the group phase to the start of a message.
module y64_byte_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] data_byte
  input  logic       s_tlast,    // is_final
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [6:0] char_code, [7] zero
  output logic       m_tlast     // end_of_text
);

  // Jobs flow from the front part into the queue.
  logic           push_valid;
  logic           push_ready;
  y64e_pkg::job_t push_job;

  // And from the queue into the back part.
  logic           pop_valid;
  logic           pop_ready;
  y64e_pkg::job_t pop_job;

  y64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  y64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  y64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

>>> rtl/y64e_checker.sv
// Port-level checks for the y64 byte stream encoder, bound to the top level.
// Depends on y64e_pkg for the pad code.
module y64e_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // Set after a pad that does not end the message: more padding must follow.
  logic pad_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_open <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      pad_open <= (m_tdata[6:0] == y64e_pkg::PAD_CHAR) && !m_tlast;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[7] && (
      (m_tdata[6:0] >= 7'h41 && m_tdata[6:0] <= 7'h5a) ||
      (m_tdata[6:0] >= 7'h61 && m_tdata[6:0] <= 7'h7a) ||
      (m_tdata[6:0] >= 7'h30 && m_tdata[6:0] <= 7'h39) ||
      m_tdata[6:0] == 7'h2e || m_tdata[6:0] == 7'h5f ||
      m_tdata[6:0] == y64e_pkg::PAD_CHAR))
    else $error("character outside the alphabet");

  a_pad_run: assert property (@(posedge clk) disable iff (rst)
    pad_open && m_tvalid |-> m_tdata[6:0] == y64e_pkg::PAD_CHAR && m_tlast)
    else $error("padding not closed by a final pad");

endmodule

bind y64_byte_stream_encoder y64e_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
